// ----- design/nnr_pkg.sv -----
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared types and constants of the nearest-neighbor power-of-two resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

  localparam int MAX_SIDE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int COORD_W    = 8;
  localparam int PIX_W      = 32;
  localparam int SIDE_W     = CFG_W + 1;
  localparam int OUT_SIDE_W = 9;
  localparam int LG_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIX_W-1:0]   pixel_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]      pixel_out;
    logic                  out_of_range;
    logic [OUT_SIDE_W-1:0] dest_side;
  } out_t;

  typedef struct packed {
    logic                  wr;
    logic                  oor;
    logic [OUT_SIDE_W-1:0] side;
  } cmd_ctl_t;

endpackage

`default_nettype wire

// ----- design/nearest_neighbor_pow2_resampler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_pow2_resampler
// Texture store with nearest-neighbor fetch into a power-of-two square.
//
//   channel  | signals                          | transfer
//   ---------+----------------------------------+--------------------------
//   item in  | start, busy, in_i                | start high, busy low
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i high
//   result   | res_valid_o, res_o               | res_valid_o, one cycle
//
// One item per cycle sustained while busy is low. A fetch passes two front
// stages (multiply, address), the queue, and the registered read of the
// single-port pixel store before its result strobe. Loads give no result.
// Reset clears control and config (sizes back to 1); the store is not
// cleared. busy rises only when the queue backs up into the front stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_pow2_resampler #(
  parameter int MAX_SIDE  = nnr_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = nnr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire nnr_pkg::in_t                  in_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nnr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nnr_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                               res_valid_o,
  output nnr_pkg::out_t                      res_o
);

  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = $bits(nnr_pkg::cmd_ctl_t) + ADDR_W + nnr_pkg::PIX_W;

  logic                      f_push, q_ready, q_valid, b_pop;
  nnr_pkg::cmd_ctl_t         f_ctl, b_ctl;
  logic [ADDR_W-1:0]         f_addr, b_addr;
  logic [nnr_pkg::PIX_W-1:0] f_data, b_data;
  logic [ENTRY_W-1:0]        q_in, q_out;

  nnr_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_i),
    .busy_o     (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (f_push),
    .ctl_o      (f_ctl),
    .addr_o     (f_addr),
    .data_o     (f_data),
    .q_ready_i  (q_ready)
  );

  assign q_in = {f_ctl, f_addr, f_data};

  nnr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (nnr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_ctl, b_addr, b_data} = q_out;

  nnr_back #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .ctl_i       (b_ctl),
    .addr_i      (b_addr),
    .data_i      (b_data),
    .pop_o       (b_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- design/nnr_ram.sv -----
// ----------------------------------------------------------------------------
// nnr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/nnr_queue.sv -----
// ----------------------------------------------------------------------------
// nnr_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full, empty, do_push, do_pop;

  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign ready_o = !full;
  assign valid_o = !empty;
  assign data_o  = mem_q[rptr_q];

endmodule

`default_nettype wire

// ----- design/nnr_front.sv -----
// ----------------------------------------------------------------------------
// nnr_front
// Config registers, item intake, range check and per-axis ratio multiply.
// Emits store commands (write or read) toward the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_front #(
  parameter int MAX_SIDE  = nnr_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = nnr_pkg::FRAC_BITS_DEF,
  parameter int ADDR_W    = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire nnr_pkg::in_t                   item_i,
  output logic                                busy_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nnr_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                push_o,
  output nnr_pkg::cmd_ctl_t                   ctl_o,
  output logic      [ADDR_W-1:0]              addr_o,
  output logic      [nnr_pkg::PIX_W-1:0]      data_o,
  input  wire logic                           q_ready_i
);

  localparam int CFG_W   = nnr_pkg::CFG_W;
  localparam int LG_W    = nnr_pkg::LG_W;
  localparam int SIDE_W  = nnr_pkg::SIDE_W;
  localparam int COORD_W = nnr_pkg::COORD_W;
  localparam int RATIO_W = CFG_W + FRAC_BITS + 1;
  localparam int PROD_W  = COORD_W + RATIO_W;
  localparam int QUO_W   = PROD_W - FRAC_BITS;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = CFG_W'(MAX_SIDE);
    end
    return r;
  endfunction

  function automatic logic [LG_W-1:0] side_log2(input logic [CFG_W-1:0] w);
    logic [LG_W-1:0] r;
    r = LG_W'(CFG_W);
    for (int i = CFG_W; i >= 0; i--) begin
      if (32'(w) <= (32'd1 << i)) r = LG_W'(i);
    end
    return r;
  endfunction

  function automatic logic [RATIO_W-1:0] axis_ratio(input logic [CFG_W-1:0] size,
                                                    input logic [LG_W-1:0]  lg);
    logic [RATIO_W-1:0] t;
    t = (RATIO_W'(size) << FRAC_BITS) >> lg;
    return t + RATIO_W'(1);
  endfunction

  function automatic logic [CFG_W-1:0] sat_axis(input logic [PROD_W-1:0] prod,
                                                input logic [CFG_W-1:0]  size);
    logic [QUO_W-1:0] q;
    logic [CFG_W-1:0] r;
    q = prod[PROD_W-1:FRAC_BITS];
    if (q >= QUO_W'(size)) begin
      r = size - CFG_W'(1);
    end else begin
      r = CFG_W'(q);
    end
    return r;
  endfunction

  // derived config, updated on the write itself
  logic [CFG_W-1:0]   w_q, h_q, wc, hc;
  logic [LG_W-1:0]    lg_q, lgn;
  logic [SIDE_W-1:0]  side_q;
  logic [RATIO_W-1:0] ratio_x_q, ratio_y_q;

  assign wc  = clamp_size(cfg_data_i);
  assign hc  = clamp_size(cfg_data_i);
  assign lgn = side_log2(wc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= CFG_W'(1);
      h_q       <= CFG_W'(1);
      lg_q      <= '0;
      side_q    <= SIDE_W'(1);
      ratio_x_q <= axis_ratio(CFG_W'(1), '0);
      ratio_y_q <= axis_ratio(CFG_W'(1), '0);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnr_pkg::CFG_WIDTH: begin
          w_q       <= wc;
          lg_q      <= lgn;
          side_q    <= SIDE_W'(1) << lgn;
          ratio_x_q <= axis_ratio(wc, lgn);
          ratio_y_q <= axis_ratio(h_q, lgn);
        end
        nnr_pkg::CFG_HEIGHT: begin
          h_q       <= hc;
          ratio_y_q <= axis_ratio(hc, lg_q);
        end
        default: ;
      endcase
    end
  end

  // stage 1: intake, range check, multiply
  nnr_pkg::in_t s1_q;
  logic         s1_valid_q, s1_valid_d;
  logic         s1_oor;
  logic [PROD_W-1:0] s1_px, s1_py;

  // stage 2: saturate, address, push
  logic               s2_valid_q, s2_valid_d;
  logic               s2_func_q, s2_oor_q;
  logic [COORD_W-1:0] s2_x_q, s2_y_q;
  logic [PROD_W-1:0]  s2_px_q, s2_py_q;
  logic [nnr_pkg::PIX_W-1:0] s2_pix_q;

  logic accept, s1_adv, s2_free, push_ok, drop, in_store, is_load;
  logic [CFG_W-1:0] sx, sy;

  assign s1_oor = (SIDE_W'(s1_q.coord_x) >= side_q) || (SIDE_W'(s1_q.coord_y) >= side_q);
  assign s1_px  = PROD_W'(s1_q.coord_x) * PROD_W'(ratio_x_q);
  assign s1_py  = PROD_W'(s1_q.coord_y) * PROD_W'(ratio_y_q);

  assign is_load  = (s2_func_q == nnr_pkg::FUNC_LOAD);
  assign in_store = (32'(s2_x_q) < MAX_SIDE) && (32'(s2_y_q) < MAX_SIDE);
  assign drop     = is_load && !in_store;
  assign push_ok  = drop || q_ready_i;
  assign s2_free  = !s2_valid_q || push_ok;
  assign s1_adv   = s1_valid_q && s2_free;
  assign busy_o   = s1_valid_q && !s2_free;
  assign accept   = start_i && !busy_o;

  assign s1_valid_d = accept || (s1_valid_q && !s2_free);
  assign s2_valid_d = s1_adv || (s2_valid_q && !push_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      s2_func_q <= s1_q.func;
      s2_oor_q  <= s1_oor;
      s2_x_q    <= s1_q.coord_x;
      s2_y_q    <= s1_q.coord_y;
      s2_px_q   <= s1_px;
      s2_py_q   <= s1_py;
      s2_pix_q  <= s1_q.pixel_in;
    end
  end

  always_comb begin
    if (is_load) begin
      sx = CFG_W'(s2_x_q);
      sy = CFG_W'(s2_y_q);
    end else begin
      sx = sat_axis(s2_px_q, w_q);
      sy = sat_axis(s2_py_q, h_q);
    end
  end

  assign push_o     = s2_valid_q && !drop;
  assign ctl_o.wr   = is_load;
  assign ctl_o.oor  = !is_load && s2_oor_q;
  assign ctl_o.side = side_q[nnr_pkg::OUT_SIDE_W-1:0];
  assign addr_o     = ADDR_W'(32'(sy) * MAX_SIDE + 32'(sx));
  assign data_o     = s2_pix_q;

endmodule

`default_nettype wire

// ----- design/nnr_back.sv -----
// ----------------------------------------------------------------------------
// nnr_back
// Drains store commands: writes source pixels, reads fetched pixels and
// drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_back #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire nnr_pkg::cmd_ctl_t         ctl_i,
  input  wire logic [ADDR_W-1:0]         addr_i,
  input  wire logic [nnr_pkg::PIX_W-1:0] data_i,
  output logic                           pop_o,
  output logic                           res_valid_o,
  output nnr_pkg::out_t                  res_o
);

  logic                              res_pend_q;
  logic                              oor_q;
  logic [nnr_pkg::OUT_SIDE_W-1:0]    side_q;
  logic [nnr_pkg::PIX_W-1:0]         rdata;

  assign pop_o = valid_i;

  nnr_ram #(
    .WIDTH (nnr_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (valid_i && ctl_i.wr),
    .addr_i  (addr_i),
    .wdata_i (data_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
    end else begin
      res_pend_q <= valid_i && !ctl_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      oor_q  <= ctl_i.oor;
      side_q <= ctl_i.side;
    end
  end

  assign res_valid_o        = res_pend_q;
  assign res_o.pixel_out    = oor_q ? '0 : rdata;
  assign res_o.out_of_range = oor_q;
  assign res_o.dest_side    = side_q;

endmodule

`default_nettype wire

// ----- design/nnr_checker.sv -----
// ----------------------------------------------------------------------------
// nnr_port_checks
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_port_checks (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire nnr_pkg::in_t  in_i,
  input wire logic          res_valid_o,
  input wire nnr_pkg::out_t res_o
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!busy && !res_valid_o))
    else $error("busy or result strobe during reset");

  a_fetch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == nnr_pkg::FUNC_FETCH) |-> ##4 res_valid_o)
    else $error("fetch transfer without result four cycles later");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.func == nnr_pkg::FUNC_LOAD) |-> ##4 !res_valid_o)
    else $error("load transfer produced a result");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_of_range) |-> (res_o.pixel_out == '0))
    else $error("out-of-range result carries a pixel");

endmodule

bind nearest_neighbor_pow2_resampler nnr_port_checks u_nnr_port_checks (.*);

`default_nettype wire
